FILE: hw/rtl/mrb_pkg.sv
// shared constants, payload types, and controller/datapath types for the message ring buffer
package mrb_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int EXT_W     = ADDR_W + 1;
  localparam int SIZE_W    = 16;
  localparam int SUM_W     = $clog2(MEM_BYTES + (1 << SIZE_W) + 8);
  localparam int CFG_W     = 13;
  localparam int CAP_W     = $clog2(MEM_BYTES + 1);
  localparam int COUNT_W   = 11;
  localparam int OFFSET_W  = 12;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int CAP_MIN   = 16;
  localparam int CAP_RESET = (MEM_BYTES < 4096) ? MEM_BYTES : 4096;
  localparam int HDR_BYTES = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [7:0]         MARKER_BYTE = 8'hff;

  // byte positions inside a header
  localparam logic [1:0] BYTE_LO   = 2'd0;
  localparam logic [1:0] BYTE_HI   = 2'd1;
  localparam logic [1:0] BYTE_TOP  = 2'd3;
  localparam logic [1:0] BYTE_LAST = 2'd3;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_PEEK  = 2'd1,
    MODE_POP   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_CORRUPT = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SIZE_W-1:0] request_size;
  } mrb_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [OFFSET_W-1:0] payload_offset;
    logic [SIZE_W-1:0]   message_size;
    logic [COUNT_W-1:0]  stored_count;
  } mrb_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_MARK,
    S_HDR,
    S_RD_TOP,
    S_CHK,
    S_RD_LO,
    S_RD_HI,
    S_RD_END,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic       capture;
    logic       eval;
    logic       mem_wr;
    logic       wr_marker;
    logic [1:0] byte_sel;
    logic       rewind;
    logic       cap_lo;
    logic       cap_hi;
    logic       set_status;
    logic [1:0] status_code;
    logic       finish;
  } mrb_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       alloc_ok;
    logic       alloc_wrap;
    logic       empty;
    logic       marker;
    logic       corrupt;
    logic       write_zero;
    logic       out_free;
  } mrb_stat_t;

endpackage

FILE: hw/rtl/mrb_ram.sv
// generic simple dual-port ram with registered read
module mrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/mrb_ctrl.sv
// sequencing state machine for the message ring buffer
module mrb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  mrb_pkg::mrb_stat_t stat,
  output mrb_pkg::mrb_cmd_t  cmd
);
  import mrb_pkg::*;

  ctrl_state_t state, state_next;
  logic [1:0]  cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // byte counter runs only while marker or header bytes are written
  always_comb begin
    if (state == S_MARK || state == S_HDR) begin
      cnt_next = cnt + 2'd1;
    end else begin
      cnt_next = '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        case (mode_t'(stat.mode))
          MODE_ALLOC: begin
            if (!stat.alloc_ok)     state_next = S_FINISH;
            else if (stat.alloc_wrap) state_next = S_MARK;
            else                    state_next = S_HDR;
          end
          MODE_CLEAR: state_next = S_FINISH;
          default: begin
            if (stat.empty) state_next = S_FINISH;
            else            state_next = S_RD_TOP;
          end
        endcase
      end
      S_MARK: begin
        if (cnt == BYTE_LAST) state_next = S_HDR;
      end
      S_HDR: begin
        if (cnt == BYTE_LAST) state_next = S_FINISH;
      end
      S_RD_TOP: state_next = S_CHK;
      S_CHK: begin
        if (stat.marker && (stat.corrupt || stat.write_zero)) state_next = S_FINISH;
        else                                                  state_next = S_RD_LO;
      end
      S_RD_LO:  state_next = S_RD_HI;
      S_RD_HI:  state_next = S_RD_END;
      S_RD_END: state_next = S_FINISH;
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = (state == S_IDLE);
    case (state)
      S_IDLE: cmd.capture = req_valid;
      S_EVAL: begin
        case (mode_t'(stat.mode))
          MODE_ALLOC: begin
            cmd.eval = 1'b1;
            if (!stat.alloc_ok) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = STATUS_EMPTY;
            end
          end
          MODE_PEEK, MODE_POP: begin
            if (stat.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = STATUS_EMPTY;
            end
          end
          default: cmd.set_status = 1'b0;
        endcase
      end
      S_MARK: begin
        cmd.mem_wr    = 1'b1;
        cmd.wr_marker = 1'b1;
        cmd.byte_sel  = cnt;
      end
      S_HDR: begin
        cmd.mem_wr   = 1'b1;
        cmd.byte_sel = cnt;
      end
      S_RD_TOP: cmd.byte_sel = BYTE_TOP;
      S_CHK: begin
        if (stat.marker) begin
          if (stat.corrupt) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = STATUS_CORRUPT;
          end else begin
            // a wrap marker sends the read side back to offset 0, even on peek
            cmd.rewind = 1'b1;
            if (stat.write_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = STATUS_EMPTY;
            end
          end
        end
      end
      S_RD_LO: cmd.byte_sel = BYTE_LO;
      S_RD_HI: begin
        cmd.byte_sel = BYTE_HI;
        cmd.cap_lo   = 1'b1;
      end
      S_RD_END: cmd.cap_hi = 1'b1;
      S_FINISH: cmd.finish = stat.out_free;
      default: cmd = '0;
    endcase
  end

  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cnt == '0))
    else $error("byte counter not at zero in idle");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == S_IDLE))
    else $error("controller did not return to idle after a result");

endmodule

FILE: hw/rtl/mrb_dp.sv
// datapath: ring indices, header store, allocation checks, and result register
module mrb_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mrb_pkg::APB_AW-1:0]   paddr,
  input  logic [mrb_pkg::APB_DW-1:0]   pwdata,
  output logic [mrb_pkg::APB_DW-1:0]   prdata,
  input  mrb_pkg::mrb_req_t            req,
  output mrb_pkg::mrb_rsp_t            rsp,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  input  mrb_pkg::mrb_cmd_t            cmd,
  output mrb_pkg::mrb_stat_t           stat
);
  import mrb_pkg::*;

  logic [CAP_W-1:0]   capacity, capacity_next;
  logic [ADDR_W-1:0]  write_index, write_index_next;
  logic [ADDR_W-1:0]  read_index, read_index_next;
  logic [COUNT_W-1:0] message_count, message_count_next;
  logic               rsp_valid_next;
  mrb_rsp_t           rsp_next;

  logic [1:0]         mode_q;
  logic [SIZE_W-1:0]  req_size;
  logic               wrap_q;
  logic [1:0]         res_status, res_status_next;
  logic [7:0]         size_lo, size_hi;
  logic               rd_oob_q;

  logic               cfg_hit;
  logic [CFG_W-1:0]   cfg_val;

  logic [SUM_W-1:0]   head_x, tail_x, req_x, cap_x;
  logic               need_wrap, fit_wrap, fit_place;

  logic [ADDR_W-1:0]  base;
  logic [EXT_W-1:0]   mem_addr;
  logic               mem_oob;
  logic [7:0]         mem_wdata, mem_rdata, rd_byte;

  logic [EXT_W-1:0]   hdr_at, alloc_off;
  logic [SUM_W-1:0]   alloc_end, pop_sum, pop_s1;
  logic [EXT_W-1:0]   read_off;

  // ---------------- configuration port
  assign cfg_hit = psel && penable && pwrite && (paddr[APB_AW-1:2] == '0);
  assign cfg_val = pwdata[CFG_W-1:0];
  assign prdata  = (paddr[APB_AW-1:2] == '0) ? APB_DW'(capacity) : '0;

  // ---------------- allocation room checks
  assign head_x    = SUM_W'(write_index);
  assign tail_x    = SUM_W'(read_index);
  assign req_x     = SUM_W'(req_size);
  assign cap_x     = SUM_W'(capacity);
  assign need_wrap = (head_x + req_x + SUM_W'(2 * HDR_BYTES)) > cap_x;
  assign fit_wrap  = (write_index >= read_index) && ((req_x + SUM_W'(HDR_BYTES + 1)) < tail_x);
  assign fit_place = (write_index >= read_index) ||
                     ((head_x + req_x + SUM_W'(HDR_BYTES + 1)) < tail_x);

  // ---------------- header store access
  always_comb begin
    if (!cmd.mem_wr)        base = read_index;
    else if (cmd.wr_marker) base = write_index;
    else if (wrap_q)        base = '0;
    else                    base = write_index;
  end

  assign mem_addr = {1'b0, base} + EXT_W'(cmd.byte_sel);
  // accesses past the end of the store are dropped on write and read as zero
  assign mem_oob  = mem_addr >= EXT_W'(MEM_BYTES);

  always_comb begin
    if (cmd.wr_marker) begin
      mem_wdata = MARKER_BYTE;
    end else begin
      case (cmd.byte_sel)
        BYTE_LO: mem_wdata = req_size[7:0];
        BYTE_HI: mem_wdata = req_size[15:8];
        default: mem_wdata = '0;
      endcase
    end
  end

  mrb_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (cmd.mem_wr && !mem_oob),
    .waddr(mem_addr[ADDR_W-1:0]),
    .wdata(mem_wdata),
    .raddr(mem_addr[ADDR_W-1:0]),
    .rdata(mem_rdata)
  );

  assign rd_byte = rd_oob_q ? 8'd0 : mem_rdata;

  // ---------------- commit arithmetic
  assign hdr_at    = wrap_q ? '0 : {1'b0, write_index};
  assign alloc_off = hdr_at + EXT_W'(HDR_BYTES);
  assign alloc_end = SUM_W'(alloc_off) + req_x;
  assign read_off  = {1'b0, read_index} + EXT_W'(HDR_BYTES);
  assign pop_sum   = tail_x + SUM_W'(HDR_BYTES) + SUM_W'({size_hi, size_lo});
  assign pop_s1    = (pop_sum >= cap_x) ? (pop_sum - cap_x) : pop_sum;

  // ---------------- status to controller
  always_comb begin
    stat            = '0;
    stat.mode       = mode_q;
    stat.alloc_ok   = need_wrap ? fit_wrap : fit_place;
    stat.alloc_wrap = need_wrap;
    stat.empty      = (read_index == write_index);
    stat.marker     = rd_byte[7];
    stat.corrupt    = (write_index > read_index);
    stat.write_zero = (write_index == '0);
    stat.out_free   = !rsp_valid || rsp_ready;
  end

  // ---------------- next state of the ring
  always_comb begin
    capacity_next      = capacity;
    write_index_next   = write_index;
    read_index_next    = read_index;
    message_count_next = message_count;
    res_status_next    = res_status;
    rsp_valid_next     = rsp_valid && !rsp_ready;
    rsp_next           = rsp;

    if (cmd.capture)    res_status_next = STATUS_OK;
    if (cmd.set_status) res_status_next = cmd.status_code;
    if (cmd.rewind)     read_index_next = '0;

    if (cmd.finish) begin
      rsp_valid_next          = 1'b1;
      rsp_next.status         = res_status;
      rsp_next.payload_offset = '0;
      rsp_next.message_size   = '0;
      if (res_status == STATUS_CORRUPT ||
          (res_status == STATUS_OK && mode_q == MODE_CLEAR)) begin
        write_index_next   = '0;
        read_index_next    = '0;
        message_count_next = '0;
      end else if (res_status == STATUS_OK) begin
        case (mode_t'(mode_q))
          MODE_ALLOC: begin
            rsp_next.payload_offset = OFFSET_W'(alloc_off);
            write_index_next = (alloc_end >= cap_x) ? '0 : alloc_end[ADDR_W-1:0];
            if (message_count != COUNT_MAX) message_count_next = message_count + 1'b1;
          end
          MODE_PEEK, MODE_POP: begin
            rsp_next.payload_offset = OFFSET_W'(read_off);
            rsp_next.message_size   = {size_hi, size_lo};
            if (mode_q == MODE_POP) begin
              // a second overshoot only comes from a damaged header
              read_index_next = (pop_s1 >= cap_x) ? '0 : pop_s1[ADDR_W-1:0];
              if (message_count != '0) message_count_next = message_count - 1'b1;
            end
          end
          default: rsp_next.payload_offset = '0;
        endcase
      end
      rsp_next.stored_count = message_count_next;
    end

    if (cfg_hit) begin
      if (32'(cfg_val) < CAP_MIN)         capacity_next = CAP_W'(CAP_MIN);
      else if (32'(cfg_val) > MEM_BYTES)  capacity_next = CAP_W'(MEM_BYTES);
      else                                capacity_next = CAP_W'(cfg_val);
      write_index_next   = '0;
      read_index_next    = '0;
      message_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_W'(CAP_RESET);
      write_index   <= '0;
      read_index    <= '0;
      message_count <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      capacity      <= capacity_next;
      write_index   <= write_index_next;
      read_index    <= read_index_next;
      message_count <= message_count_next;
      rsp_valid     <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= req.mode;
      req_size <= req.request_size;
    end
    if (cmd.eval)   wrap_q  <= need_wrap;
    if (cmd.cap_lo) size_lo <= rd_byte;
    if (cmd.cap_hi) size_hi <= rd_byte;
    res_status <= res_status_next;
    rd_oob_q   <= mem_oob;
    rsp        <= rsp_next;
  end

  a_write_in_ring: assert property (@(posedge clk) disable iff (rst)
    CAP_W'(write_index) < capacity)
    else $error("write index outside the ring");

  a_read_in_ring: assert property (@(posedge clk) disable iff (rst)
    CAP_W'(read_index) < capacity)
    else $error("read index outside the ring");

  a_finish_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> rsp_valid)
    else $error("finished operation left no result");

endmodule

FILE: hw/rtl/message_ring_buffer_unit.sv
// top level of the variable-length message ring buffer
//
//   port group   direction  handshake            payload
//   req          in         req_valid/req_ready  mrb_req_t (mode, request_size)
//   rsp          out        rsp_valid/rsp_ready  mrb_rsp_t (status, offset, size, count)
//   apb          in/out     psel/penable/pready  capacity_bytes at address 0
//
// one operation at a time through a byte-wide header store port; allocate writes 4 header
// bytes, after 4 marker bytes when it wraps and none when refused; peek/pop read the top
// byte, then the two size bytes (three byte reads through the registered read port),
// none when empty, and stop after the top byte when a wrap marker clears a corrupt ring
// or leaves it empty; clear resets the ring. a finished result waits in the output
// register; a stalled rsp side holds the block in its last step until that register frees
// synchronous reset clears indices and count; header store contents are never read
// before written, so no clearing pass is run

module message_ring_buffer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrb_pkg::APB_AW-1:0]  paddr,
  input  logic [mrb_pkg::APB_DW-1:0]  pwdata,
  output logic [mrb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  mrb_pkg::mrb_req_t           req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output mrb_pkg::mrb_rsp_t           rsp
);
  import mrb_pkg::*;

  mrb_cmd_t  cmd;
  mrb_stat_t stat;

  assign pready = 1'b1;

  mrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mrb_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .req      (req),
    .rsp      (rsp),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
